### rtl/mmpr_pkg.sv
package mmpr_pkg;

  // Exponent width and the counter that walks its bits.
  localparam int EXP_BITS = 63;
  localparam int BIT_W    = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  // Residues are 30 bits wide; the modulus needs exactly that many bits.
  localparam int VAL_W    = 30;
  localparam int PROD_W   = 2 * VAL_W;
  localparam int MULT_W   = 32;

  localparam logic [VAL_W-1:0]  MODULUS   = VAL_W'(1000000007);
  localparam logic [MULT_W-1:0] MOD_W32   = MULT_W'(1000000007);
  localparam logic [MULT_W-1:0] TWO_MOD   = MULT_W'(2000000014);

  // Barrett constant floor(2^(2*VAL_W) / MODULUS), evaluated at elaboration.
  localparam logic [63:0] BARRETT_MU = (64'd1 << PROD_W) / 64'd1000000007;

  // Configuration register indexes.
  localparam int NUM_REGS = 6;
  localparam int IDX_W    = 3;
  localparam logic [IDX_W-1:0] REG_COEF00 = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COEF01 = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_COEF10 = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_COEF11 = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_START0 = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_START1 = IDX_W'(5);

  // Which right-hand operand the current matrix product uses.
  typedef enum logic [1:0] {
    MODE_SQUARE = 2'd0,
    MODE_BASE   = 2'd1,
    MODE_VECTOR = 2'd2
  } mode_e;

  // A register value may sit at or above the modulus; one subtraction fixes it.
  function automatic logic [VAL_W-1:0] reduce_once(input logic [VAL_W-1:0] x);
    reduce_once = (x >= MODULUS) ? (x - MODULUS) : x;
  endfunction

endpackage

### rtl/modular_matrix_power_recurrence_top.sv
// Sequence: the operands are loaded, then each exponent bit down to and including the
// highest set bit is scanned; each lower bit costs a matrix square, plus a multiply by
// the base when it is set; then the final vector product runs and the result is handed over.
// Throughput: one item at a time; the shared 32x32 multiplier with its Barrett reduction
// (8 modular products per matrix product) sets the rate.
// Reset: asynchronous, active low; the configuration registers return to the Fibonacci matrix and start.
module modular_matrix_power_recurrence_top
  import mmpr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_index_i,
  input  logic [VAL_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [EXP_BITS-1:0] exponent_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [VAL_W-1:0]    term_value_o
);

  // The sequencer walks the exponent from its top bit. Until the first set bit
  // the accumulator is the identity, so squaring is skipped and the first set
  // bit simply loads the base matrix. Every later bit costs one matrix square
  // and, when set, one multiply by the base. A matrix product is eight modular
  // products, each run through the one shared multiplier in three passes:
  // the plain product, then the two Barrett multiplies that reduce it.
  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_PREP   = 10'b00_0000_0010,
    S_SCAN   = 10'b00_0000_0100,
    S_MUL    = 10'b00_0000_1000,
    S_BAR1   = 10'b00_0001_0000,
    S_BAR2   = 10'b00_0010_0000,
    S_FIX    = 10'b00_0100_0000,
    S_ACC    = 10'b00_1000_0000,
    S_COMMIT = 10'b01_0000_0000,
    S_FIN    = 10'b10_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic              id_q, id_d;
  mode_e             mode_q, mode_d;
  logic [2:0]        k_q, k_d;
  logic              out_valid_q;
  logic [VAL_W-1:0]  out_q;

  logic [VAL_W-1:0]    cfg_q [NUM_REGS];
  logic [EXP_BITS-1:0] exp_q;
  logic [VAL_W-1:0]    base_q [4];
  logic [VAL_W-1:0]    acc_q  [4];
  logic [VAL_W-1:0]    new_q  [4];
  logic [VAL_W-1:0]    svec_q [2];

  // Barrett pipeline registers.
  logic [PROD_W-1:0]   x_q;
  logic [VAL_W:0]      q3_q;
  logic [MULT_W-1:0]   r_q;
  logic [VAL_W-1:0]    fr_q;
  logic [VAL_W-1:0]    sum_q;

  logic [MULT_W-1:0]   mop_a, mop_b;
  logic [63:0]         prod;
  logic [1:0]          a_idx, b_idx;
  logic [1:0]          e_idx;
  logic                k_last;
  logic                cur_bit;
  logic [VAL_W-1:0]    fix_val;
  logic [VAL_W:0]      add_sum;
  logic [VAL_W-1:0]    add_mod;
  logic                fin_load;

  // Term k of a product: row k[2], column k[1], inner index k[0].
  assign a_idx   = {k_q[2], k_q[0]};
  assign b_idx   = {k_q[0], k_q[1]};
  assign e_idx   = {k_q[2], k_q[1]};
  assign k_last  = (mode_q == MODE_VECTOR) ? (k_q == 3'd1) : (k_q == 3'd7);
  assign cur_bit = exp_q[bit_q];

  // The one shared multiplier and its operand selection.
  always_comb begin
    mop_a = '0;
    mop_b = '0;
    unique case (state_q)
      S_MUL: begin
        mop_a = MULT_W'(acc_q[a_idx]);
        unique case (mode_q)
          MODE_SQUARE: mop_b = MULT_W'(acc_q[b_idx]);
          MODE_BASE:   mop_b = MULT_W'(base_q[b_idx]);
          MODE_VECTOR: mop_b = MULT_W'(svec_q[k_q[0]]);
          default:     mop_b = '0;
        endcase
      end
      S_BAR1: begin
        mop_a = MULT_W'(x_q[PROD_W-1:VAL_W-1]);
        mop_b = BARRETT_MU[MULT_W-1:0];
      end
      S_BAR2: begin
        mop_a = MULT_W'(q3_q);
        mop_b = MOD_W32;
      end
      default: begin
        mop_a = '0;
        mop_b = '0;
      end
    endcase
  end

  assign prod = {32'd0, mop_a} * {32'd0, mop_b};

  // Barrett leaves a remainder below three moduli.
  always_comb begin
    if (r_q >= TWO_MOD) begin
      fix_val = VAL_W'(r_q - TWO_MOD);
    end else if (r_q >= MOD_W32) begin
      fix_val = VAL_W'(r_q - MOD_W32);
    end else begin
      fix_val = VAL_W'(r_q);
    end
  end

  assign add_sum = {1'b0, sum_q} + {1'b0, fr_q};
  assign add_mod = (add_sum >= {1'b0, MODULUS}) ? VAL_W'(add_sum - {1'b0, MODULUS})
                                                : VAL_W'(add_sum);

  assign fin_load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    id_d    = id_q;
    mode_d  = mode_q;
    k_d     = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        state_d = S_SCAN;
        bit_d   = BIT_W'(EXP_BITS - 1);
        id_d    = 1'b1;
      end
      S_SCAN: begin
        if (id_q) begin
          if (cur_bit) begin
            id_d = 1'b0;
          end
          if (bit_q == '0) begin
            mode_d  = MODE_VECTOR;
            k_d     = '0;
            state_d = S_MUL;
          end else begin
            bit_d = bit_q - 1'b1;
          end
        end else begin
          mode_d  = MODE_SQUARE;
          k_d     = '0;
          state_d = S_MUL;
        end
      end
      S_MUL:  state_d = S_BAR1;
      S_BAR1: state_d = S_BAR2;
      S_BAR2: state_d = S_FIX;
      S_FIX:  state_d = S_ACC;
      S_ACC: begin
        if (k_last) begin
          state_d = (mode_q == MODE_VECTOR) ? S_FIN : S_COMMIT;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_COMMIT: begin
        if ((mode_q == MODE_SQUARE) && cur_bit) begin
          mode_d  = MODE_BASE;
          k_d     = '0;
          state_d = S_MUL;
        end else if (bit_q == '0) begin
          mode_d  = MODE_VECTOR;
          k_d     = '0;
          state_d = S_MUL;
        end else begin
          bit_d   = bit_q - 1'b1;
          state_d = S_SCAN;
        end
      end
      S_FIN: begin
        if (fin_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bit_q       <= '0;
      id_q        <= 1'b1;
      mode_q      <= MODE_SQUARE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      cfg_q[0]    <= VAL_W'(0);
      cfg_q[1]    <= VAL_W'(1);
      cfg_q[2]    <= VAL_W'(1);
      cfg_q[3]    <= VAL_W'(1);
      cfg_q[4]    <= VAL_W'(0);
      cfg_q[5]    <= VAL_W'(1);
    end else begin
      state_q     <= state_d;
      bit_q       <= bit_d;
      id_q        <= id_d;
      mode_q      <= mode_d;
      k_q         <= k_d;
      out_valid_q <= (out_valid_q && !out_ready_i) || fin_load;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_COEF00: cfg_q[0] <= cfg_wdata_i;
          REG_COEF01: cfg_q[1] <= cfg_wdata_i;
          REG_COEF10: cfg_q[2] <= cfg_wdata_i;
          REG_COEF11: cfg_q[3] <= cfg_wdata_i;
          REG_START0: cfg_q[4] <= cfg_wdata_i;
          REG_START1: cfg_q[5] <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          exp_q <= exponent_i;
        end
      end
      S_PREP: begin
        for (int i = 0; i < 4; i++) begin
          base_q[i] <= reduce_once(cfg_q[i]);
        end
        svec_q[0] <= reduce_once(cfg_q[4]);
        svec_q[1] <= reduce_once(cfg_q[5]);
        acc_q[0]  <= VAL_W'(1);
        acc_q[1]  <= '0;
        acc_q[2]  <= '0;
        acc_q[3]  <= VAL_W'(1);
      end
      S_SCAN: begin
        if (id_q && cur_bit) begin
          acc_q <= base_q;
        end
      end
      S_MUL:  x_q  <= prod[PROD_W-1:0];
      S_BAR1: q3_q <= prod[2*VAL_W+1:VAL_W+1];
      S_BAR2: r_q  <= x_q[MULT_W-1:0] - prod[MULT_W-1:0];
      S_FIX:  fr_q <= fix_val;
      S_ACC: begin
        if (!k_q[0]) begin
          sum_q <= fr_q;
        end else begin
          new_q[e_idx] <= add_mod;
        end
      end
      S_COMMIT: acc_q <= new_q;
      S_FIN: begin
        if (fin_load) begin
          out_q <= new_q[0];
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign term_value_o = out_q;

  // A delivered term is always a fully reduced residue.
  a_out_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (term_value_o < MODULUS))
    else $error("term value not reduced below the modulus");

  // An accepted item starts operand loading on the next cycle.
  a_accept_prep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_PREP))
    else $error("accepted item did not start operand loading");

  // The correction step always hands a reduced value to the accumulator.
  a_fix_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (fr_q < MODULUS))
    else $error("Barrett remainder not reduced");

  // Matrix products only run once the accumulator has left the identity.
  a_square_after_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_MUL) && (mode_q != MODE_VECTOR)) |-> !id_q)
    else $error("matrix product started while accumulator is the identity");

endmodule
